FILE: rtl/core/ewcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the eye window center search.
package ewcs_pkg;

	localparam int CH_W    = 7;
	localparam int TAP_W   = 8;
	localparam int SMP_W   = 16;
	localparam int LEN_W   = 9;
	localparam int PROD_W  = 14;
	localparam logic [LEN_W-1:0] LEN_MAX     = 9'd511;
	localparam logic [4:0]       GROWTH_NUM  = 5'd18;
	localparam int               GROWTH_SHIFT = 4;

	typedef struct packed {
		logic [SMP_W-1:0] last_sample;
		logic [TAP_W-1:0] run_start;
		logic [LEN_W-1:0] run_length;
		logic [TAP_W-1:0] best_start;
		logic [LEN_W-1:0] best_length;
	} ewcs_state_t;

endpackage

FILE: rtl/core/ewcs_lane_mem.sv
`timescale 1ns / 1ps
// Per-lane state memory: one write port, one registered read port, valid bits.
module ewcs_lane_mem #(
	parameter int LANES = 65,
	parameter int AW    = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output ewcs_pkg::ewcs_state_t rd_data,
	output logic                  rd_hit,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  ewcs_pkg::ewcs_state_t wr_data
);
	import ewcs_pkg::*;

	ewcs_state_t       mem [LANES];
	logic [LANES-1:0]  written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit    <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit <= written_q[rd_addr];
			end
		end
	end

	// a written entry stays marked
	a_written_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> written_q[$past(wr_addr)])
		else $error("written lane lost its valid bit");

endmodule

FILE: rtl/core/ewcs_update.sv
`timescale 1ns / 1ps
// Run and best-eye update for one lane sample.
module ewcs_update (
	input  ewcs_pkg::ewcs_state_t       cur,
	input  logic [ewcs_pkg::TAP_W-1:0]  tap,
	input  logic [ewcs_pkg::SMP_W-1:0]  smp,
	output ewcs_pkg::ewcs_state_t       nxt,
	output logic [ewcs_pkg::TAP_W-1:0]  center
);
	import ewcs_pkg::*;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] limit;

	always_comb begin
		prod  = PROD_W'(cur.best_length) * PROD_W'(GROWTH_NUM);
		limit = prod >> GROWTH_SHIFT;
		nxt   = cur;
		if (smp == cur.last_sample) begin
			if (cur.run_length < LEN_MAX) begin
				nxt.run_length = cur.run_length + 9'd1;
			end
		end else begin
			// ended run replaces best only if it beats 18/16 of it
			if (PROD_W'(cur.run_length) > limit) begin
				nxt.best_start  = cur.run_start;
				nxt.best_length = cur.run_length;
			end
			nxt.run_length = '0;
			nxt.run_start  = tap;
		end
		nxt.last_sample = smp;
		center = nxt.best_start + nxt.best_length[LEN_W-1:1];
	end

endmodule

FILE: rtl/core/eye_window_center_search.sv
`timescale 1ns / 1ps
// Top level of the eye window center search: per-lane delay scan tracking.
//
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall  channel, delay_tap, sample
//  out      out  out_valid/ out_stall out_channel, eye_start, eye_width, eye_center
//
// One item per cycle sustained while in_stall is low. An item is accepted, its lane
// state is read from the lane memory at that edge, then updated in s1 and written
// back when s1 fires; the item just ahead is forwarded from a write-back register
// when lanes match. A result (last tap only) is registered when its item leaves s1.
// Reset clears the lane valid bits at once; unwritten lanes read as scan defaults,
// so there is no clearing pass. Tap 0 restarts a lane from the defaults.
// in_stall rises only while s1 holds a last-tap item and the output register is
// full and stalled. Out-of-range lanes or taps are dropped without a result.
module eye_window_center_search #(
	parameter int LANES       = 65,
	parameter int DELAY_STEPS = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ewcs_pkg::CH_W-1:0]    channel,
	input  logic [ewcs_pkg::TAP_W-1:0]   delay_tap,
	input  logic [ewcs_pkg::SMP_W-1:0]   sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ewcs_pkg::CH_W-1:0]    out_channel,
	output logic [ewcs_pkg::TAP_W-1:0]   eye_start,
	output logic [ewcs_pkg::LEN_W-1:0]   eye_width,
	output logic [ewcs_pkg::TAP_W-1:0]   eye_center
);
	import ewcs_pkg::*;

	localparam int AW = (LANES > 1) ? $clog2(LANES) : 1;
	localparam logic [SMP_W-1:0] SMP_MASK  = SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [TAP_W-1:0] TAP_LAST  = TAP_W'(DELAY_STEPS - 1);
	localparam ewcs_state_t      SCAN_INIT = '{last_sample: SMP_MASK, default: '0};

	// input side
	logic in_accept;
	logic in_range;

	// stage 1
	logic              vld_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [AW-1:0]     idx_s1;
	logic [TAP_W-1:0]  tap_s1;
	logic [SMP_W-1:0]  smp_s1;
	logic              last_s1;
	logic              hold_s1;
	logic              fire_s1;

	// memory and forwarding
	ewcs_state_t       rd_data;
	logic              rd_hit;
	ewcs_state_t       fwd_data_q;
	logic [AW-1:0]     fwd_idx_q;
	logic              fwd_vld_q;
	ewcs_state_t       cur;
	ewcs_state_t       nxt;
	logic [TAP_W-1:0]  center;

	assign in_range  = ({1'b0, channel} < 8'(LANES)) && ({1'b0, delay_tap} < 9'(DELAY_STEPS));
	assign in_accept = in_valid && !in_stall;

	assign last_s1  = (tap_s1 == TAP_LAST);
	assign hold_s1  = vld_s1 && last_s1 && out_valid && out_stall;
	assign fire_s1  = vld_s1 && !hold_s1;
	assign in_stall = hold_s1;

	ewcs_lane_mem #(
		.LANES (LANES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_addr (channel[AW-1:0]),
		.rd_data (rd_data),
		.rd_hit  (rd_hit),
		.wr_en   (fire_s1),
		.wr_addr (idx_s1),
		.wr_data (nxt)
	);

	// lane state source: scan restart, item just ahead, memory, or defaults
	always_comb begin
		if (tap_s1 == '0) begin
			cur = SCAN_INIT;
		end else if (fwd_vld_q && (fwd_idx_q == idx_s1)) begin
			cur = fwd_data_q;
		end else if (rd_hit) begin
			cur = rd_data;
		end else begin
			cur = SCAN_INIT;
		end
	end

	ewcs_update u_upd (
		.cur    (cur),
		.tap    (tap_s1),
		.smp    (smp_s1),
		.nxt    (nxt),
		.center (center)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_accept) begin
				vld_s1 <= in_range;
			end else if (fire_s1) begin
				vld_s1 <= 1'b0;
			end
			if (fire_s1) begin
				fwd_vld_q <= 1'b1;
			end
			if (fire_s1 && last_s1) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ch_s1  <= channel;
			idx_s1 <= channel[AW-1:0];
			tap_s1 <= delay_tap;
			smp_s1 <= sample & SMP_MASK;
		end
		if (fire_s1) begin
			fwd_data_q <= nxt;
			fwd_idx_q  <= idx_s1;
		end
		if (fire_s1 && last_s1) begin
			out_channel <= ch_s1;
			eye_start   <= nxt.best_start;
			eye_width   <= nxt.best_length;
			eye_center  <= center;
		end
	end

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && out_valid))
		else $error("input stalled without a held item");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> out_valid)
		else $error("last-tap item produced no result");

	a_center_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (eye_center == TAP_W'(eye_start + eye_width[LEN_W-1:1])))
		else $error("eye center does not match start and width");

	a_no_write_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		hold_s1 |=> vld_s1)
		else $error("held item left stage 1");

endmodule

FILE: sim/eye_window_center_search_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the eye window center search: per-lane scans, saturation, stalls.
module eye_window_center_search_test;
	import ewcs_pkg::*;

	localparam int LANES        = 65;
	localparam int LAST_TAP     = 255;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 500000;

	// Scan defaults: sample all ones, everything else zero (last_sample is the top field).
	localparam ewcs_state_t SCAN_DEFAULT =
		{{SMP_W{1'b1}}, {($bits(ewcs_state_t) - SMP_W){1'b0}}};

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [CH_W-1:0]  lane;
		logic [TAP_W-1:0] start;
		logic [LEN_W-1:0] width;
		logic [TAP_W-1:0] center;
	} eye_result_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             out_stall = 1'b0;
	logic [CH_W-1:0]  channel   = '0;
	logic [TAP_W-1:0] delay_tap = '0;
	logic [SMP_W-1:0] sample    = '0;
	logic             in_stall;
	logic             out_valid;
	logic [CH_W-1:0]  out_channel;
	logic [TAP_W-1:0] eye_start;
	logic [LEN_W-1:0] eye_width;
	logic [TAP_W-1:0] eye_center;

	// Predictor state: one scan record per lane, plus the eyes still owed by the block.
	ewcs_state_t lane_scan[LANES];
	eye_result_t eye_results_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_armed     = 1'b0;
	int hold_left      = 0;
	int fail_count     = 0;
	int cycle_count    = 0;

	eye_window_center_search i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.channel     (channel),
		.delay_tap   (delay_tap),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.eye_start   (eye_start),
		.eye_width   (eye_width),
		.eye_center  (eye_center)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall per cycle, or a long hold-off when a test arms one.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Result checker. Sampled at the falling edge, so the values are the ones the
	// next rising edge sees; a result taken there is compared with the oldest eye owed.
	initial begin
		eye_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (eye_results_q.size() == 0) begin
					$error("unexpected eye result on lane %0d", out_channel);
					fail_count++;
				end else begin
					want = eye_results_q.pop_front();
					if (out_channel !== want.lane) begin
						$error("out_channel: expected %0d, got %0d", want.lane, out_channel);
						fail_count++;
					end
					if (eye_start !== want.start) begin
						$error("eye_start: expected %0d, got %0d", want.start, eye_start);
						fail_count++;
					end
					if (eye_width !== want.width) begin
						$error("eye_width: expected %0d, got %0d", want.width, eye_width);
						fail_count++;
					end
					if (eye_center !== want.center) begin
						$error("eye_center: expected %0d, got %0d", want.center, eye_center);
						fail_count++;
					end
				end
			end
		end
	end

	// Per-lane eye tracking for one accepted item.
	task automatic predict_lane_scan(input logic [CH_W-1:0] lane,
			input logic [TAP_W-1:0] tap, input logic [SMP_W-1:0] smp);
		ewcs_state_t st;
		int          limit;
		int          mid;
		eye_result_t res;
		if (lane >= LANES)
			return;
		st = (tap == 0) ? SCAN_DEFAULT : lane_scan[lane];
		if (smp == st.last_sample) begin
			if (st.run_length < LEN_MAX)
				st.run_length++;
		end else begin
			// a new eye must beat the best by more than 1/8 to take over
			limit = (int'(st.best_length) * int'(GROWTH_NUM)) >> GROWTH_SHIFT;
			if (int'(st.run_length) > limit) begin
				st.best_start  = st.run_start;
				st.best_length = st.run_length;
			end
			st.run_length = '0;
			st.run_start  = tap;
		end
		st.last_sample  = smp;
		lane_scan[lane] = st;
		if (tap == LAST_TAP) begin
			mid        = int'(st.best_start) + int'(st.best_length >> 1);
			res.lane   = lane;
			res.start  = st.best_start;
			res.width  = st.best_length;
			res.center = mid[TAP_W-1:0];
			eye_results_q.push_back(res);
		end
	endtask

	// Offer one item, optionally after an idle gap; returns at the edge that takes it.
	task automatic send_sample(input logic [CH_W-1:0] lane, input logic [TAP_W-1:0] tap,
			input logic [SMP_W-1:0] smp);
		int  gap;
		logic stalled;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		channel   <= lane;
		delay_tap <= tap;
		sample    <= smp;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		predict_lane_scan(lane, tap, smp);
	endtask

	// Always waits on the clock before it first checks, so the next item is driven in a later step.
	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (eye_results_q.size() != 0);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 84;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 84;
			end
			IDLE_BOTH: begin
				send_idle_pct  = 8;
				recv_stall_pct = 8;
			end
		endcase
	endtask

	// Sample levels: mostly a few repeating words so runs form, sometimes anything.
	function automatic logic [SMP_W-1:0] random_level();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			2:       return SMP_W'($urandom);
			default: return SMP_W'($urandom_range(3)) * 16'h5555;
		endcase
	endfunction

	// Hand-built scans: lane and tap extremes, ignored lanes, a run left open at the
	// last tap, the 18/16 replacement rule at a tie and just above it, taps out of order.
	task automatic test_directed_scans();
		int t;
		set_idling(IDLE_NONE);
		// lane 0: reset level repeats from tap 0, closed at the last tap
		send_sample(7'd0, 8'd0, 16'hFFFF);
		send_sample(7'd0, 8'd128, 16'hFFFF);
		send_sample(7'd0, 8'd255, 16'h0000);
		// lane 64: run still open at the last tap, no eye recorded
		send_sample(7'd64, 8'd0, 16'h0000);
		send_sample(7'd64, 8'd255, 16'h0000);
		// lanes past the top are dropped
		send_sample(7'd65, 8'd255, 16'h1234);
		send_sample(7'd127, 8'd0, 16'hFFFF);
		// lane 1: best of 2, a tie of 2 keeps it, a run of 3 replaces it
		t = 0;
		repeat (3) send_sample(7'd1, TAP_W'(t++), 16'hA5A5);
		repeat (3) send_sample(7'd1, TAP_W'(t++), 16'h5A5A);
		repeat (4) send_sample(7'd1, TAP_W'(t++), 16'h00FF);
		send_sample(7'd1, 8'd255, 16'hFF00);
		// lane 2: taps out of order are processed as they come
		send_sample(7'd2, 8'd0, 16'h8001);
		send_sample(7'd2, 8'd200, 16'h8001);
		send_sample(7'd2, 8'd100, 16'h8001);
		send_sample(7'd2, 8'd255, 16'h7FFE);
		wait_drain();
	endtask

	// Run length saturates at 511; the eye center sum wraps past 255.
	task automatic test_run_saturation();
		set_idling(IDLE_SENDER);
		send_sample(7'd33, 8'd0, 16'h0F0F);
		send_sample(7'd33, 8'd200, 16'hF0F0);
		repeat (520) send_sample(7'd33, TAP_W'($urandom_range(201, 254)), 16'hF0F0);
		send_sample(7'd33, 8'd255, 16'h0000);
		wait_drain();
	endtask

	// Mostly well-formed interleaved scans from tap 0 to the last tap, with single
	// stray items and broken scans mixed in.
	task automatic test_random_scans(input idle_mode_t mode, input int n_items);
		int              sent;
		int              n_lanes;
		int              left;
		int              pick;
		int              step;
		int              j;
		int              k;
		bit              dup;
		logic [CH_W-1:0] lanes[4];
		int              next_tap[4];
		logic [SMP_W-1:0] level[4];
		bit              done[4];
		logic [CH_W-1:0] lane;
		set_idling(mode);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 80) begin
				n_lanes = $urandom_range(1, 4);
				for (k = 0; k < n_lanes; k++) begin
					do begin
						if ($urandom_range(9) == 0)
							lanes[k] = $urandom_range(1) ? CH_W'(LANES - 1) : '0;
						else
							lanes[k] = CH_W'($urandom_range(0, LANES - 1));
						dup = 1'b0;
						for (j = 0; j < k; j++)
							if (lanes[j] == lanes[k])
								dup = 1'b1;
					end while (dup);
					next_tap[k] = 0;
					level[k]    = random_level();
					done[k]     = 1'b0;
				end
				left = n_lanes;
				while (left > 0) begin
					pick = $urandom_range(0, n_lanes - 1);
					if (done[pick])
						continue;
					if ($urandom_range(3) == 0)
						level[pick] = random_level();
					send_sample(lanes[pick], TAP_W'(next_tap[pick]), level[pick]);
					sent++;
					if (next_tap[pick] == LAST_TAP) begin
						done[pick] = 1'b1;
						left--;
					end else begin
						step = $urandom_range(1) ? $urandom_range(1, 40) : $urandom_range(1, 3);
						next_tap[pick] = (next_tap[pick] + step > LAST_TAP) ?
							LAST_TAP : next_tap[pick] + step;
					end
				end
			end else if ($urandom_range(1)) begin
				// stray item, any lane code including the dropped ones
				lane = CH_W'($urandom_range(0, 127));
				send_sample(lane, TAP_W'($urandom_range(0, 255)), SMP_W'($urandom));
				if (lane < LANES)
					sent++;
			end else begin
				// broken scan: no restart at tap 0, taps in any order
				lane = CH_W'($urandom_range(0, LANES - 1));
				repeat ($urandom_range(2, 6)) begin
					send_sample(lane, TAP_W'($urandom_range(1, 255)), random_level());
					sent++;
				end
			end
		end
		wait_drain();
	endtask

	// Receiver holds off while short scans keep ending; the output fills and in_stall rises.
	task automatic test_output_hold();
		int i;
		set_idling(IDLE_NONE);
		hold_armed = 1'b1;
		for (i = 0; i < 10; i++) begin
			send_sample(CH_W'(i * 7), 8'd0, SMP_W'($urandom));
			send_sample(CH_W'(i * 7), 8'd255, SMP_W'($urandom));
		end
		send_sample(CH_W'(LANES - 1), 8'd0, 16'hFFFF);
		send_sample(CH_W'(LANES - 1), 8'd255, 16'hFFFF);
		wait_drain();
	endtask

	// Sender goes quiet after each scan until its eye has come out.
	task automatic test_paused_scans();
		logic [CH_W-1:0] lane;
		logic [SMP_W-1:0] lvl;
		int              t;
		set_idling(IDLE_BOTH);
		repeat (4) begin
			lane = CH_W'($urandom_range(0, LANES - 1));
			lvl  = random_level();
			send_sample(lane, 8'd0, lvl);
			for (t = 64; t < LAST_TAP; t += 64)
				send_sample(lane, TAP_W'(t), ($urandom_range(2) == 0) ? random_level() : lvl);
			send_sample(lane, 8'd255, random_level());
			wait_drain();
		end
	endtask

	initial begin
		for (int i = 0; i < LANES; i++)
			lane_scan[i] = SCAN_DEFAULT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_scans();
		test_run_saturation();
		test_random_scans(IDLE_NONE, 270);
		test_random_scans(IDLE_SENDER, 270);
		test_random_scans(IDLE_RECEIVER, 270);
		test_random_scans(IDLE_BOTH, 270);
		test_output_hold();
		test_paused_scans();

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
